// ===== rtl/core/rbpi_pkg.sv =====
// ----------------------------------------------------------------------------
// Rigid body pose integrator package
// Transaction types, register codes and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package rbpi_pkg;

   localparam logic [31:0] STEP_SIZE_RESET = 32'd4294967;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = 32 / DIV_STEPS;
   localparam int RSP_LATENCY = 5 + 1 + DIV_STAGES + 3;

   localparam logic REG_STEP_SIZE     = 1'b0;
   localparam logic REG_IMPLICIT_MODE = 1'b1;

   localparam logic KIND_POSITION    = 1'b0;
   localparam logic KIND_ORIENTATION = 1'b1;

   typedef struct packed {
      logic              kind;
      logic signed [31:0] a0;
      logic signed [31:0] a1;
      logic signed [31:0] a2;
      logic signed [31:0] a3;
      logic signed [31:0] b0;
      logic signed [31:0] b1;
      logic signed [31:0] b2;
   } req_type;

   typedef struct packed {
      logic              kind_out;
      logic signed [31:0] r0;
      logic signed [31:0] r1;
      logic signed [31:0] r2;
      logic signed [31:0] r3;
   } rsp_type;

   typedef struct packed {
      logic [31:0] step_size;
      logic        implicit_mode;
   } cfg_type;

   typedef struct packed {
      logic             kind;
      logic [3:0][31:0] a;
      logic [3:0][31:0] r_direct;
   } side_type;

   typedef struct packed {
      side_type         side;
      logic [62:0]      den;
      logic [3:0][51:0] num;
      logic [3:0]       neg;
   } front_type;

   typedef struct packed {
      logic [62:0] rem;
      logic [31:0] quo;
      logic        neg;
      logic        big;
   } lane_type;

   typedef struct packed {
      side_type          side;
      logic [62:0]       den;
      lane_type [3:0]    lane;
   } div_type;

   function automatic logic [31:0] sat32(input logic signed [65:0] x);
      logic [31:0] res;
      if (x > 66'sd2147483647) begin
         res = 32'h7FFF_FFFF;
      end else if (x < -66'sd2147483648) begin
         res = 32'h8000_0000;
      end else begin
         res = x[31:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/rbpi_csr.sv =====
// ----------------------------------------------------------------------------
// Rigid body pose integrator register file
// APB-style access to step size and update mode.
// ----------------------------------------------------------------------------
module rbpi_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output rbpi_pkg::cfg_type cfg
);
   import rbpi_pkg::*;

   logic [31:0] step_size_ff, step_size_in;
   logic        implicit_ff, implicit_in;
   logic        wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      step_size_in = step_size_ff;
      implicit_in  = implicit_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_STEP_SIZE:     step_size_in = pwdata;
            REG_IMPLICIT_MODE: implicit_in  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= STEP_SIZE_RESET;
         implicit_ff  <= 1'b0;
      end else begin
         step_size_ff <= step_size_in;
         implicit_ff  <= implicit_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_STEP_SIZE:     prdata = step_size_ff;
         REG_IMPLICIT_MODE: prdata = {31'b0, implicit_ff};
         default:           prdata = '0;
      endcase
   end

   assign cfg.step_size     = step_size_ff;
   assign cfg.implicit_mode = implicit_ff;

endmodule

// ===== rtl/core/rbpi_front.sv =====
// ----------------------------------------------------------------------------
// Rigid body pose integrator front end
// Five stages: products, sums, step scaling, increment, denominator.
// ----------------------------------------------------------------------------
module rbpi_front (
   input  logic                 clock,
   input  logic                 reset,
   input  rbpi_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   input  rbpi_pkg::req_type    in_data,
   output logic                 out_valid,
   output rbpi_pkg::front_type  out_data
);
   import rbpi_pkg::*;

   logic [4:0] valid_ff;

   // stage 1
   logic             s1_kind_ff;
   logic [3:0][31:0] s1_a_ff;
   logic signed [63:0] s1_prod_ff [4][3];
   logic signed [63:0] s1_bb_ff [3];
   logic [63:0]        s1_hh_ff;
   logic signed [64:0] s1_hv_ff [3];
   // stage 2
   logic             s2_kind_ff;
   logic [3:0][31:0] s2_a_ff;
   logic signed [63:0] s2_sum_ff [4];
   logic signed [63:0] s2_sum_in [4];
   logic [63:0]        s2_w2_ff;
   logic [63:0]        s2_hh_ff;
   logic [2:0][31:0]   s2_pos_ff, s2_pos_in;
   // stage 3
   logic             s3_kind_ff;
   logic [3:0][31:0] s3_a_ff;
   logic signed [64:0] s3_ph_ff [4];
   logic [63:0]        s3_pl_ff [4];
   logic [63:0]        s3_ll_ff, s3_lh_ff, s3_hl_ff, s3_hh_ff;
   logic [2:0][31:0]   s3_pos_ff;
   // stage 4
   logic             s4_kind_ff;
   logic [3:0][31:0] s4_a_ff;
   logic signed [51:0] s4_n_ff [4];
   logic signed [51:0] s4_n_in [4];
   logic [33:0]        s4_mid_ff;
   logic [63:0]        s4_hs_ff;
   logic [2:0][31:0]   s4_pos_ff;
   // stage 5
   front_type          s5_ff, s5_in;

   logic [31:0]        b_v [3];
   logic [31:0]        a_v [4];

   assign a_v[0] = in_data.a0;
   assign a_v[1] = in_data.a1;
   assign a_v[2] = in_data.a2;
   assign a_v[3] = in_data.a3;
   assign b_v[0] = in_data.b0;
   assign b_v[1] = in_data.b1;
   assign b_v[2] = in_data.b2;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff <= in_data.kind;
      for (int i = 0; i < 4; i++) begin
         s1_a_ff[i] <= a_v[i];
         for (int j = 0; j < 3; j++) begin
            s1_prod_ff[i][j] <= $signed(a_v[i]) * $signed(b_v[j]);
         end
      end
      for (int j = 0; j < 3; j++) begin
         s1_bb_ff[j] <= $signed(b_v[j]) * $signed(b_v[j]);
         s1_hv_ff[j] <= $signed({1'b0, cfg.step_size}) * $signed(b_v[j]);
      end
      s1_hh_ff <= 64'(cfg.step_size) * 64'(cfg.step_size);
   end

   // stage 2: floored product sums, squared rate, position update
   always_comb begin
      logic signed [63:0] q [4][3];
      logic signed [64:0] hr;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 3; j++) begin
            q[i][j] = s1_prod_ff[i][j] >>> 2;
         end
      end
      s2_sum_in[0] = q[3][0] + q[1][2] - q[2][1];
      s2_sum_in[1] = q[3][1] + q[2][0] - q[0][2];
      s2_sum_in[2] = q[3][2] + q[0][1] - q[1][0];
      s2_sum_in[3] = -(q[0][0] + q[1][1] + q[2][2]);
      for (int j = 0; j < 3; j++) begin
         hr = (s1_hv_ff[j] + 65'sd2147483648) >>> 32;
         s2_pos_in[j] = sat32(66'($signed(s1_a_ff[j])) + 66'(hr));
      end
   end

   always_ff @(posedge clock) begin
      s2_kind_ff <= s1_kind_ff;
      s2_a_ff    <= s1_a_ff;
      s2_sum_ff  <= s2_sum_in;
      s2_w2_ff   <= 64'(s1_bb_ff[0]) + 64'(s1_bb_ff[1]) + 64'(s1_bb_ff[2]);
      s2_hh_ff   <= s1_hh_ff;
      s2_pos_ff  <= s2_pos_in;
   end

   // stage 3: step size times sums, partial products of h^2 * |omega|^2
   always_ff @(posedge clock) begin
      s3_kind_ff <= s2_kind_ff;
      s3_a_ff    <= s2_a_ff;
      s3_pos_ff  <= s2_pos_ff;
      for (int i = 0; i < 4; i++) begin
         s3_ph_ff[i] <= $signed({1'b0, cfg.step_size}) * $signed(s2_sum_ff[i][63:32]);
         s3_pl_ff[i] <= 64'(cfg.step_size) * 64'(s2_sum_ff[i][31:0]);
      end
      s3_ll_ff <= 64'(s2_hh_ff[31:0])  * 64'(s2_w2_ff[31:0]);
      s3_lh_ff <= 64'(s2_hh_ff[31:0])  * 64'(s2_w2_ff[63:32]);
      s3_hl_ff <= 64'(s2_hh_ff[63:32]) * 64'(s2_w2_ff[31:0]);
      s3_hh_ff <= 64'(s2_hh_ff[63:32]) * 64'(s2_w2_ff[63:32]);
   end

   // stage 4: rounded increment, unsaturated update
   always_comb begin
      logic signed [65:0] t;
      logic signed [65:0] inc;
      for (int i = 0; i < 4; i++) begin
         t = 66'(s3_ph_ff[i]) + $signed({34'b0, s3_pl_ff[i][63:32]}) + 66'sd16384;
         inc = t >>> 15;
         s4_n_in[i] = 52'(66'($signed(s3_a_ff[i])) + inc);
      end
   end

   always_ff @(posedge clock) begin
      s4_kind_ff <= s3_kind_ff;
      s4_a_ff    <= s3_a_ff;
      s4_pos_ff  <= s3_pos_ff;
      s4_n_ff    <= s4_n_in;
      s4_mid_ff  <= 34'(s3_ll_ff[63:32]) + 34'(s3_lh_ff[31:0]) + 34'(s3_hl_ff[31:0]);
      s4_hs_ff   <= s3_hh_ff + 64'(s3_lh_ff[63:32]) + 64'(s3_hl_ff[63:32]);
   end

   // stage 5: denominator, magnitudes, explicit result
   always_comb begin
      logic [63:0] hi;
      hi = s4_hs_ff + 64'(s4_mid_ff[33:32]);
      s5_in.den       = 63'(hi[63:2]) + 63'h1_0000_0000;
      s5_in.side.kind = s4_kind_ff;
      s5_in.side.a    = s4_a_ff;
      for (int i = 0; i < 4; i++) begin
         s5_in.neg[i] = s4_n_ff[i] < 0;
         s5_in.num[i] = s5_in.neg[i] ? 52'(-s4_n_ff[i]) : 52'(s4_n_ff[i]);
         if (s4_kind_ff == KIND_ORIENTATION) begin
            s5_in.side.r_direct[i] = sat32(66'(s4_n_ff[i]));
         end else if (i < 3) begin
            s5_in.side.r_direct[i] = s4_pos_ff[i];
         end else begin
            s5_in.side.r_direct[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s5_ff <= s5_in;
   end

   assign out_valid = valid_ff[4];
   assign out_data  = s5_ff;

endmodule

// ===== rtl/core/rbpi_div.sv =====
// ----------------------------------------------------------------------------
// Rigid body pose integrator divider
// Pipelined restoring division of four lanes by a shared denominator.
// ----------------------------------------------------------------------------
module rbpi_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  rbpi_pkg::front_type in_data,
   output logic                out_valid,
   output rbpi_pkg::div_type   out_data
);
   import rbpi_pkg::*;

   div_type    stage_ff [DIV_STAGES+1];
   div_type    stage_in [DIV_STAGES+1];
   logic [DIV_STAGES:0] valid_ff;

   always_comb begin
      logic [52:0] num2;
      logic [63:0] t;
      stage_in[0].side = in_data.side;
      stage_in[0].den  = in_data.den;
      for (int l = 0; l < 4; l++) begin
         num2 = {in_data.num[l], 1'b0};
         stage_in[0].lane[l].big = {10'b0, num2} >= in_data.den;
         stage_in[0].lane[l].rem = stage_in[0].lane[l].big ? '0 : {10'b0, num2};
         stage_in[0].lane[l].quo = '0;
         stage_in[0].lane[l].neg = in_data.neg[l];
      end
      for (int s = 1; s <= DIV_STAGES; s++) begin
         stage_in[s] = stage_ff[s-1];
         for (int l = 0; l < 4; l++) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
               t = {stage_in[s].lane[l].rem, 1'b0};
               if (t >= {1'b0, stage_in[s].den}) begin
                  stage_in[s].lane[l].rem = 63'(t - {1'b0, stage_in[s].den});
                  stage_in[s].lane[l].quo = {stage_in[s].lane[l].quo[30:0], 1'b1};
               end else begin
                  stage_in[s].lane[l].rem = t[62:0];
                  stage_in[s].lane[l].quo = {stage_in[s].lane[l].quo[30:0], 1'b0};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
         stage_ff[s] <= stage_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DIV_STAGES-1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[DIV_STAGES];
   assign out_data  = stage_ff[DIV_STAGES];

endmodule

// ===== rtl/core/rbpi_align.sv =====
// ----------------------------------------------------------------------------
// Rigid body pose integrator output stage
// Rounding and saturation of quotients, hemisphere alignment, result register.
// ----------------------------------------------------------------------------
module rbpi_align (
   input  logic              clock,
   input  logic              reset,
   input  rbpi_pkg::cfg_type cfg,
   input  logic              in_valid,
   input  rbpi_pkg::div_type in_data,
   output logic              out_valid,
   output rbpi_pkg::rsp_type out_data
);
   import rbpi_pkg::*;

   logic [2:0]       valid_ff;
   logic             f1_kind_ff, f2_kind_ff;
   logic [3:0][31:0] f1_a_ff;
   logic [3:0][31:0] f1_r_ff, f1_r_in, f2_r_ff, f3_r_in;
   logic signed [63:0] f2_prod_ff [4];
   rsp_type          out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_comb begin
      logic        sat;
      logic [32:0] mag;
      for (int l = 0; l < 4; l++) begin
         sat = in_data.lane[l].big || (&in_data.lane[l].quo);
         mag = ({1'b0, in_data.lane[l].quo} + 33'd1) >> 1;
         if (!(cfg.implicit_mode && in_data.side.kind == KIND_ORIENTATION)) begin
            f1_r_in[l] = in_data.side.r_direct[l];
         end else if (sat) begin
            f1_r_in[l] = in_data.lane[l].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            f1_r_in[l] = in_data.lane[l].neg ? -mag[31:0] : mag[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      f1_kind_ff <= in_data.side.kind;
      f1_a_ff    <= in_data.side.a;
      f1_r_ff    <= f1_r_in;
   end

   always_ff @(posedge clock) begin
      f2_kind_ff <= f1_kind_ff;
      f2_r_ff    <= f1_r_ff;
      for (int l = 0; l < 4; l++) begin
         f2_prod_ff[l] <= $signed(f1_r_ff[l]) * $signed(f1_a_ff[l]);
      end
   end

   always_comb begin
      logic signed [65:0] dot;
      logic               flip;
      dot = '0;
      for (int l = 0; l < 4; l++) begin
         dot = dot + 66'(f2_prod_ff[l] >>> 2);
      end
      flip = (f2_kind_ff == KIND_ORIENTATION) && (dot < 0);
      for (int l = 0; l < 4; l++) begin
         if (!flip) begin
            f3_r_in[l] = f2_r_ff[l];
         end else if (f2_r_ff[l] == 32'h8000_0000) begin
            f3_r_in[l] = 32'h7FFF_FFFF;
         end else begin
            f3_r_in[l] = -f2_r_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff.kind_out <= f2_kind_ff;
      out_ff.r0       <= f3_r_in[0];
      out_ff.r1       <= f3_r_in[1];
      out_ff.r2       <= f3_r_in[2];
      out_ff.r3       <= f3_r_in[3];
   end

   assign out_valid = valid_ff[2];
   assign out_data  = out_ff;

endmodule

// ===== rtl/core/rigid_body_pose_integrator_core.sv =====
// ----------------------------------------------------------------------------
// Rigid body pose integrator core
// Integrates a position or a quaternion over one time step per transaction.
// ----------------------------------------------------------------------------
// One transaction enters per clock cycle while busy is low, and its result
// leaves in order, one cycle of rsp_strobe per transaction. The pipeline has
// five multiply and sum stages, one setup stage and sixteen two-bit stages of
// the shared-denominator divider, and three rounding and alignment stages.
// busy is high only while reset is applied and for the cycle after, so the
// sender never waits otherwise; the receiver must take every result as it
// appears. Change step_size or implicit_mode only while no transaction is in
// flight.
module rigid_body_pose_integrator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rbpi_pkg::req_type req_data,
   output logic              rsp_strobe,
   output rbpi_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import rbpi_pkg::*;

   cfg_type   cfg;
   logic      busy_ff;
   logic      front_valid, div_valid;
   front_type front_data;
   div_type   div_data;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy = busy_ff;

   rbpi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rbpi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (start && !busy_ff),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   rbpi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   rbpi_align u_align (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, RSP_LATENCY))
      else $error("result without matching transaction");

   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.kind_out == $past(req_data.kind, RSP_LATENCY))
      else $error("result kind does not match transaction");

   a_pos_w_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.kind_out == KIND_POSITION |-> rsp_data.r3 == '0)
      else $error("position result with nonzero scalar");
`endif

endmodule
